// ----- hw/rtl/byte_pattern_search_assert.svh -----
// Assertion macros for the byte pattern search checker
`ifndef BYTE_PATTERN_SEARCH_ASSERT_SVH
`define BYTE_PATTERN_SEARCH_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define BPS_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("byte_pattern_search assertion failed");

// Consequent must hold in the cycle after the antecedent
`define BPS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("byte_pattern_search assertion failed");

`endif

// ----- hw/rtl/bps_pkg.sv -----
// Types and constants of the byte pattern search block
`timescale 1ns / 1ps
`default_nettype none

package bps_pkg;

    localparam int DATA_W      = 8;
    localparam int IDX_W       = 4;
    localparam int LEN_W       = 5;
    localparam int SEEN_W      = 17;
    localparam int OFFSET_W    = 16;
    localparam int S_TDATA_W   = 16;
    localparam int M_TDATA_W   = 24;
    localparam int LEN_MAX     = 31;

    localparam longint unsigned HAYSTACK_LIMIT = 64'd65536;
    localparam longint unsigned OFFSET_CAP     = 64'd65535;
    // largest start offset that may still be reported
    localparam logic [SEEN_W:0] OFFSET_LIMIT =
        (HAYSTACK_LIMIT - 64'd1 < OFFSET_CAP) ? (SEEN_W+1)'(HAYSTACK_LIMIT - 64'd1)
                                               : (SEEN_W+1)'(OFFSET_CAP);

    typedef enum logic {
        MODE_LOAD     = 1'b0,
        MODE_HAYSTACK = 1'b1
    } mode_t;

    typedef struct packed {
        logic              shift;
        logic              clear;
        logic              pat_we;
        logic [IDX_W-1:0]  pat_idx;
        logic [DATA_W-1:0] pat_byte;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// ----- hw/rtl/bps_cell.sv -----
// One search cell: a window byte, a pattern byte and its byte comparators
`timescale 1ns / 1ps
`default_nettype none

module bps_cell #(
    parameter int MAX_PATTERN = 16,
    parameter int CELL_IDX    = 0
) (
    input  wire logic                                      aclk,
    input  wire logic                                      aresetn,
    input  wire bps_pkg::cell_ctrl_t                       ctrl,
    input  wire logic [bps_pkg::DATA_W-1:0]                win_in,
    input  wire logic [MAX_PATTERN-1:0][bps_pkg::DATA_W-1:0] pattern_all,
    output logic      [bps_pkg::DATA_W-1:0]                win_out,
    output logic      [bps_pkg::DATA_W-1:0]                pat_out,
    output logic      [MAX_PATTERN-1:0]                    eq_out
);

    logic [bps_pkg::DATA_W-1:0] win_reg;
    logic [bps_pkg::DATA_W-1:0] win_next;
    logic [bps_pkg::DATA_W-1:0] pat_reg;
    logic                       pat_hit;

    assign pat_hit = ctrl.pat_we &&
                     (32'(ctrl.pat_idx) == 32'(CELL_IDX));

    always_comb begin
        win_next = win_reg;
        if (ctrl.clear) begin
            win_next = '0;
        end else if (ctrl.shift) begin
            win_next = win_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg <= '0;
        end else begin
            win_reg <= win_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pat_hit) begin
            pat_reg <= ctrl.pat_byte;
        end
    end

    // compare the byte entering this slot against every pattern byte
    always_comb begin
        for (int k = 0; k < MAX_PATTERN; k++) begin
            eq_out[k] = (win_in == pattern_all[k]);
        end
    end

    assign win_out = win_reg;
    assign pat_out = pat_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/byte_pattern_search.sv -----
// Top level of the streaming byte pattern search
// Usage:
//   cfg_*     : write pattern_length (0..16) while the block is idle; always ready.
//   s_axis_*  : one request per byte. tuser = mode: load a pattern byte at
//               pattern_index, or feed a haystack byte. tlast closes a haystack.
//   m_axis_*  : one result per request: found flag, offset of the first match,
//               tlast set on the result of the closing haystack byte.
// Results are registered for the cycle after the request. One request per cycle is
// taken while the receiver keeps up; the compare of every window slot against
// the pattern happens in the row of cells in the same cycle the byte enters.
// When the receiver stalls, the result is held in the output register and
// s_axis_tready drops until it is taken.
// Reset clears the window, byte counter, match state and length register. The
// pattern bytes are not cleared and must be loaded before use.
// After the result of a closing byte, the search state restarts; pattern and
// length are kept.
`timescale 1ns / 1ps
`default_nettype none

module byte_pattern_search #(
    parameter int MAX_PATTERN = 16
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // configuration: pattern_length
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [bps_pkg::LEN_W-1:0]       cfg_data,
    // input stream
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [7:0] data_byte, [11:8] pattern_index, [15:12] zero
    input  wire logic [bps_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // [0] mode
    input  wire logic                            s_axis_tuser,
    input  wire logic                            s_axis_tlast,
    // result stream
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // [0] found, [16:1] match_offset, [23:17] zero
    output logic      [bps_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    output logic                                 m_axis_tlast
);

    localparam int DW   = bps_pkg::DATA_W;
    localparam int SW   = bps_pkg::SEEN_W;
    localparam int OW   = bps_pkg::OFFSET_W;
    localparam int LW   = bps_pkg::LEN_W;
    localparam int CLAMP = (MAX_PATTERN > bps_pkg::LEN_MAX) ? bps_pkg::LEN_MAX : MAX_PATTERN;

    logic [LW-1:0]  pattern_length_reg;
    logic [SW-1:0]  bytes_seen_reg;
    logic [SW-1:0]  bytes_seen_next;
    logic           match_seen_reg;
    logic           match_seen_next;
    logic [OW-1:0]  first_offset_reg;
    logic [OW-1:0]  first_offset_next;
    logic           m_valid_reg;
    logic           m_valid_next;
    logic           m_found_reg;
    logic [OW-1:0]  m_offset_reg;
    logic           m_last_reg;

    logic           accept;
    logic           is_hay;
    logic           done;
    logic [LW-1:0]  len_used;
    logic           match_sel;
    logic [SW:0]    pos_plus;
    logic [SW:0]    start;
    logic           enough;

    bps_pkg::mode_t     mode;
    bps_pkg::cell_ctrl_t ctrl;

    logic [MAX_PATTERN-1:0][DW-1:0]          win_q;
    logic [MAX_PATTERN-1:0][DW-1:0]          win_in;
    logic [MAX_PATTERN-1:0][DW-1:0]          pattern_all;
    logic [MAX_PATTERN-1:0][MAX_PATTERN-1:0] eq;
    logic [MAX_PATTERN:0]                    match_vec;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = !m_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign mode          = bps_pkg::mode_t'(s_axis_tuser);
    assign is_hay        = (mode == bps_pkg::MODE_HAYSTACK);
    assign done          = accept && is_hay && s_axis_tlast;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_length_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            pattern_length_reg <= cfg_data;
        end
    end

    assign len_used = (pattern_length_reg > LW'(CLAMP)) ? LW'(CLAMP) : pattern_length_reg;

    always_comb begin
        ctrl.shift    = accept && is_hay;
        ctrl.clear    = done;
        ctrl.pat_we   = accept && (mode == bps_pkg::MODE_LOAD);
        ctrl.pat_idx  = s_axis_tdata[bps_pkg::IDX_W+DW-1:DW];
        ctrl.pat_byte = s_axis_tdata[DW-1:0];
    end

    // row of cells: slot 0 takes the new byte, slot j takes slot j-1
    for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
        if (j == 0) begin : g_head
            assign win_in[j] = s_axis_tdata[DW-1:0];
        end else begin : g_body
            assign win_in[j] = win_q[j-1];
        end

        bps_cell #(
            .MAX_PATTERN (MAX_PATTERN),
            .CELL_IDX    (j)
        ) u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctrl        (ctrl),
            .win_in      (win_in[j]),
            .pattern_all (pattern_all),
            .win_out     (win_q[j]),
            .pat_out     (pattern_all[j]),
            .eq_out      (eq[j])
        );
    end

    // window slot j lines up with pattern byte L-1-j for a pattern of length L
    always_comb begin
        match_vec[0] = 1'b1;
        for (int l = 1; l <= MAX_PATTERN; l++) begin
            match_vec[l] = 1'b1;
            for (int j = 0; j < l; j++) begin
                match_vec[l] = match_vec[l] & eq[j][l-1-j];
            end
        end
    end

    always_comb begin
        match_sel = 1'b0;
        for (int l = 0; l <= CLAMP; l++) begin
            match_sel = match_sel | ((len_used == LW'(l)) & match_vec[l]);
        end
    end

    assign pos_plus = {1'b0, bytes_seen_reg} + (SW+1)'(1);
    assign enough   = (pos_plus >= (SW+1)'(len_used));
    assign start    = pos_plus - (SW+1)'(len_used);

    always_comb begin
        bytes_seen_next   = bytes_seen_reg;
        match_seen_next   = match_seen_reg;
        first_offset_next = first_offset_reg;
        if (accept && is_hay) begin
            if (bytes_seen_reg != {SW{1'b1}}) begin
                bytes_seen_next = bytes_seen_reg + SW'(1);
            end
            if (!match_seen_reg) begin
                if (len_used == '0) begin
                    match_seen_next   = 1'b1;
                    first_offset_next = '0;
                end else if (enough && match_sel && (start <= bps_pkg::OFFSET_LIMIT)) begin
                    match_seen_next   = 1'b1;
                    first_offset_next = start[OW-1:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bytes_seen_reg   <= '0;
            match_seen_reg   <= 1'b0;
            first_offset_reg <= '0;
        end else if (done) begin
            bytes_seen_reg   <= '0;
            match_seen_reg   <= 1'b0;
            first_offset_reg <= '0;
        end else begin
            bytes_seen_reg   <= bytes_seen_next;
            match_seen_reg   <= match_seen_next;
            first_offset_reg <= first_offset_next;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (accept) begin
            m_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // hold the result until taken
    always_ff @(posedge aclk) begin
        if (accept) begin
            m_found_reg  <= match_seen_next;
            m_offset_reg <= match_seen_next ? first_offset_next : '0;
            m_last_reg   <= done;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {{(bps_pkg::M_TDATA_W-OW-1){1'b0}}, m_offset_reg, m_found_reg};
    assign m_axis_tlast  = m_last_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/bps_checker.sv -----
// Port-level checker for the byte pattern search, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

`include "byte_pattern_search_assert.svh"

module bps_checker (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_axis_tvalid,
    input  wire logic                          s_axis_tready,
    input  wire logic                          s_axis_tuser,
    input  wire logic                          m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    input  wire logic [bps_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input  wire logic                          m_axis_tlast
);

    logic load_req;

    assign load_req = s_axis_tvalid && s_axis_tready &&
                      (s_axis_tuser == bps_pkg::MODE_LOAD);

    `BPS_ASSERT_NEXT(a_stall_hold, aclk, aresetn, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    `BPS_ASSERT_NEXT(a_req_gives_result, aclk, aresetn, s_axis_tvalid && s_axis_tready, m_axis_tvalid)
    `BPS_ASSERT_NOW(a_offset_zero_if_absent, aclk, aresetn, m_axis_tvalid && !m_axis_tdata[0], m_axis_tdata[16:1] == 16'd0)
    `BPS_ASSERT_NEXT(a_load_not_done, aclk, aresetn, load_req, !m_axis_tlast)

endmodule

bind byte_pattern_search bps_checker u_bps_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

// ----- tb/tb_byte_pattern_search.sv -----
// Self-checking testbench for the streaming byte pattern search block
`timescale 1ns / 1ps

module tb_byte_pattern_search;

    typedef struct packed {
        logic        found;
        logic [15:0] offset;
        logic        done;
    } search_result_t;

    // Tracks the search state seen from the pins and holds the results still owed
    class search_scoreboard;
        logic [7:0]     pattern_bytes [16];
        logic [7:0]     window [16];
        logic [4:0]     pattern_len;
        int unsigned    bytes_seen;
        bit             match_seen;
        logic [15:0]    first_offset;
        search_result_t expected_q [$];
        int unsigned    errors;
        int unsigned    results_checked;
        int unsigned    haystacks_closed;
        int unsigned    haystacks_matched;

        function new();
            foreach (pattern_bytes[i]) pattern_bytes[i] = 8'h00;
            pattern_len = 5'd0;
            errors = 0;
            results_checked = 0;
            haystacks_closed = 0;
            haystacks_matched = 0;
            clear_search();
        endfunction

        function void clear_search();
            foreach (window[i]) window[i] = 8'h00;
            bytes_seen = 0;
            match_seen = 0;
            first_offset = 16'd0;
        endfunction

        function void set_length(logic [4:0] value);
            pattern_len = value;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_request(bps_pkg::mode_t mode, logic [7:0] data_b, logic [3:0] idx,
                                   logic is_last);
            int unsigned    used_len;
            int unsigned    pos;
            int unsigned    start_at;
            bit             hit;
            search_result_t exp;
            exp.done = 1'b0;
            if (mode == bps_pkg::MODE_LOAD) begin
                pattern_bytes[idx] = data_b;
            end else begin
                used_len = (pattern_len > 5'd16) ? 16 : pattern_len;
                pos = bytes_seen;
                for (int k = 15; k > 0; k--) window[k] = window[k-1];
                window[0] = data_b;
                // counter sticks at its top value
                if (bytes_seen < 32'h1FFFF) bytes_seen++;
                if (!match_seen) begin
                    if (used_len == 0) begin
                        match_seen = 1;
                        first_offset = 16'd0;
                    end else if (pos + 1 >= used_len) begin
                        hit = 1;
                        for (int k = 0; k < used_len; k++)
                            if (pattern_bytes[k] != window[used_len - 1 - k]) hit = 0;
                        start_at = pos + 1 - used_len;
                        if (hit && start_at <= 65535) begin
                            match_seen = 1;
                            first_offset = start_at[15:0];
                        end
                    end
                end
                exp.done = is_last;
            end
            exp.found = match_seen;
            exp.offset = match_seen ? first_offset : 16'd0;
            expected_q.push_back(exp);
            if (exp.done) clear_search();
        endfunction

        function void check_result(logic [23:0] tdata, logic tlast);
            search_result_t exp;
            bit             bad;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result tdata=%h tlast=%b", $time, tdata, tlast);
                return;
            end
            exp = expected_q.pop_front();
            results_checked++;
            bad = 0;
            if (tdata[0] !== exp.found) begin
                bad = 1;
                $display("%0t: found expected %b actual %b", $time, exp.found, tdata[0]);
            end
            if (tdata[16:1] !== exp.offset) begin
                bad = 1;
                $display("%0t: match_offset expected %0d actual %0d",
                         $time, exp.offset, tdata[16:1]);
            end
            if (tlast !== exp.done) begin
                bad = 1;
                $display("%0t: done expected %b actual %b", $time, exp.done, tlast);
            end
            if (tdata[23:17] !== 7'd0) begin
                bad = 1;
                $display("%0t: padding expected 0 actual %h", $time, tdata[23:17]);
            end
            if (bad) errors++;
            if (exp.done) begin
                haystacks_closed++;
                if (exp.found) haystacks_matched++;
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [4:0]  cfg_data = 5'd0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = 16'd0;   // [7:0] data_byte, [11:8] pattern_index
    logic        s_axis_tuser = 1'b0;    // [0] mode
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;           // [0] found, [16:1] match_offset
    logic        m_axis_tlast;

    search_scoreboard sb = new();
    int unsigned requests_taken = 0;
    int unsigned requests_sent = 0;
    int unsigned cfg_writes = 0;
    int unsigned send_idle_pct = 35;
    int unsigned recv_idle_pct = 70;
    logic [7:0]  pattern_image [16];
    logic [4:0]  phase_len [12];

    byte_pattern_search #(.MAX_PATTERN(16)) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(negedge aclk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Note the request before checking so a same-edge result still pops the oldest
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                sb.set_length(cfg_data);
                cfg_writes++;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                sb.note_request(bps_pkg::mode_t'(s_axis_tuser), s_axis_tdata[7:0],
                                s_axis_tdata[11:8], s_axis_tlast);
                requests_taken++;
            end
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata, m_axis_tlast);
        end
    end

    initial begin
        #1_000_000;
        $display("Verification failed");
        $finish;
    end

    task automatic send_req(bps_pkg::mode_t mode, logic [7:0] data_b, logic [3:0] idx,
                            logic is_last);
        int unsigned taken_before;
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge aclk);
        end
        taken_before = requests_taken;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {4'b0000, idx, data_b};
        s_axis_tuser <= mode;
        s_axis_tlast <= is_last;
        requests_sent++;
        wait (requests_taken != taken_before);
        @(negedge aclk);
    endtask

    task automatic load_pattern(logic [3:0] idx, logic [7:0] value, logic is_last);
        pattern_image[idx] = value;
        send_req(bps_pkg::MODE_LOAD, value, idx, is_last);
    endtask

    // Hold off until every result is in, then let the pipe settle
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_length(logic [4:0] value);
        int unsigned writes_before;
        writes_before = cfg_writes;
        cfg_valid <= 1'b1;
        cfg_data <= value;
        wait (cfg_writes != writes_before);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Haystacks drawn about half from pattern bytes, often with a planted copy
    task automatic search_phase(int unsigned used_len, int unsigned item_goal);
        int unsigned first_req;
        int unsigned hay_len;
        int unsigned plant_at;
        logic [7:0]  hay [$];
        first_req = requests_sent;
        while (requests_sent - first_req < item_goal) begin
            if ($urandom_range(99) < 25) begin
                repeat ($urandom_range(1, 4))
                    load_pattern(4'($urandom_range(15)), 8'($urandom), 1'($urandom));
            end
            hay_len = ($urandom_range(9) == 0) ? $urandom_range(40, 64) : $urandom_range(1, 24);
            hay.delete();
            repeat (hay_len)
                hay.push_back($urandom_range(1) ? pattern_image[$urandom_range(15)]
                                                : 8'($urandom));
            if (used_len != 0 && hay_len >= used_len && $urandom_range(99) < 60) begin
                plant_at = $urandom_range(hay_len - used_len);
                for (int k = 0; k < used_len; k++) hay[plant_at + k] = pattern_image[k];
                // spoil the planted copy now and then to get near misses
                if ($urandom_range(3) == 0)
                    hay[plant_at + $urandom_range(used_len - 1)] ^= 8'(1 << $urandom_range(7));
            end
            foreach (hay[i]) begin
                if ($urandom_range(99) < 4)
                    load_pattern(4'($urandom_range(15)), 8'($urandom), 1'($urandom));
                send_req(bps_pkg::MODE_HAYSTACK, hay[i], 4'($urandom), i == hay.size() - 1);
            end
        end
    endtask

    initial begin
        phase_len = '{5'd1, 5'd16, 5'd0, 5'd5, 5'd31, 5'd3, 5'd2, 5'd8,
                      5'd17, 5'd4, 5'd16, 5'd1};
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // fill the whole store; a closing mark on a load has no effect
        for (int i = 0; i < 16; i++) load_pattern(4'(i), 8'(i * 17), i == 15);
        // empty pattern: the first haystack byte matches at offset zero
        send_req(bps_pkg::MODE_HAYSTACK, 8'hA5, 4'hF, 1'b0);
        load_pattern(4'd5, 8'h55, 1'b1);
        send_req(bps_pkg::MODE_HAYSTACK, 8'h00, 4'h0, 1'b1);
        drain();
        write_length(5'd3);
        // haystack shorter than the pattern, then an exact fit
        send_req(bps_pkg::MODE_HAYSTACK, 8'h00, 4'h0, 1'b0);
        send_req(bps_pkg::MODE_HAYSTACK, 8'h11, 4'h0, 1'b1);
        send_req(bps_pkg::MODE_HAYSTACK, 8'h00, 4'h0, 1'b0);
        send_req(bps_pkg::MODE_HAYSTACK, 8'h11, 4'h0, 1'b0);
        send_req(bps_pkg::MODE_HAYSTACK, 8'h22, 4'h0, 1'b1);

        for (int p = 0; p < 12; p++) begin
            drain();
            case (p / 4)
                0: begin
                    send_idle_pct = 35;
                    recv_idle_pct = 70;
                end
                1: begin
                    send_idle_pct = 70;
                    recv_idle_pct = 35;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            write_length(phase_len[p]);
            search_phase((phase_len[p] > 5'd16) ? 16 : phase_len[p], 125);
        end

        drain();
        $display("Checked %0d results from %0d requests; %0d haystacks closed, %0d with a match.",
                 sb.results_checked, requests_taken, sb.haystacks_closed, sb.haystacks_matched);
        $display("Empty, short and oversized patterns under three idle mixes, "
                 , "with planted and spoiled copies.");
        if (sb.errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
